[sv/csm_pkg.sv]
// Shared types, register map, menu codes and segment helpers for the clock set menu.
package csm_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SHORT_MIN  = 3'd0;
  localparam logic [2:0] REG_SHORT_MAX  = 3'd1;
  localparam logic [2:0] REG_LONG_MIN   = 3'd2;
  localparam logic [2:0] REG_BLINK_HALF = 3'd3;
  localparam logic [2:0] REG_DOT_HALF   = 3'd4;

  // Menu states
  localparam logic [1:0] MENU_SHOW    = 2'd0;
  localparam logic [1:0] MENU_SET_MIN = 2'd1;
  localparam logic [1:0] MENU_SET_HR  = 2'd2;

  localparam logic [10:0] TICKS_MAX   = 11'd2047;
  localparam logic [9:0]  BLINK_MAX   = 10'd1023;
  localparam logic [5:0]  MINUTES_TOP = 6'd59;
  localparam logic [4:0]  HOURS_TOP   = 5'd23;
  localparam logic [7:0]  SEG_BLANK   = 8'hFF;
  localparam logic [7:0]  SEG_DOT_CLR = 8'h7F;
  localparam logic [7:0]  SEG_DOT_SET = 8'h80;

  localparam logic [10:0] RST_SHORT_MIN  = 11'd20;
  localparam logic [10:0] RST_SHORT_MAX  = 11'd800;
  localparam logic [10:0] RST_LONG_MIN   = 11'd1000;
  localparam logic [9:0]  RST_BLINK_HALF = 10'd300;
  localparam logic [10:0] RST_DOT_HALF   = 11'd1000;

  typedef struct packed {
    logic       key_level;
    logic [4:0] time_hours;
    logic [5:0] time_minutes;
  } in_word_t;

  typedef struct packed {
    logic        write_time;
    logic [4:0]  new_hours;
    logic [5:0]  new_minutes;
    logic [31:0] digit_segments;
    logic [3:0]  anode_enable;
    logic [1:0]  menu_mode;
  } out_word_t;

  // Active-low PGFEDCBA codes, point off
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Tens digit of a value below 64
  function automatic logic [2:0] tens6(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units6(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] r;
    r = v - (6'(t) * 6'd10);
    return r[3:0];
  endfunction

endpackage

[sv/clock_set_menu_with_display.sv]
// Clock set menu: key press timing, menu state and four-digit display codes.
//
// One input word per millisecond tick: key level plus the hours and minutes
// read from the real-time clock. Each word gives exactly one result word:
// an optional time-write request, the four segment codes, digit enables
// and the menu state after the tick.
// Channels use valid/stall; a word moves on an edge with valid high and
// stall low. Timing bounds and blink/dot periods sit on an APB port
// (byte address 4*index); write them only while the block is idle.
// Each word passes the input register, then the result register, where
// out_valid rises. Throughput: one word per cycle while the receiver does
// not stall, set by the single pass of counters and compares between them.
// When the receiver stalls, the result register holds, the input register
// fills and then in_stall rises; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties both stages, returns the menu to
// show, clears the press and blink/dot timers and reloads default bounds.
module clock_set_menu_with_display (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  csm_pkg::in_word_t         in_word,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output csm_pkg::out_word_t        out_word,
  // configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [csm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [csm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [csm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  // ---------------- configuration registers ----------------
  logic [10:0] short_min_r, short_max_r, long_min_r, dot_half_r;
  logic [9:0]  blink_half_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r  <= csm_pkg::RST_SHORT_MIN;
      short_max_r  <= csm_pkg::RST_SHORT_MAX;
      long_min_r   <= csm_pkg::RST_LONG_MIN;
      blink_half_r <= csm_pkg::RST_BLINK_HALF;
      dot_half_r   <= csm_pkg::RST_DOT_HALF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        csm_pkg::REG_SHORT_MIN:  short_min_r  <= cfg_pwdata[10:0];
        csm_pkg::REG_SHORT_MAX:  short_max_r  <= cfg_pwdata[10:0];
        csm_pkg::REG_LONG_MIN:   long_min_r   <= cfg_pwdata[10:0];
        csm_pkg::REG_BLINK_HALF: blink_half_r <= cfg_pwdata[9:0];
        csm_pkg::REG_DOT_HALF:   dot_half_r   <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      csm_pkg::REG_SHORT_MIN:  cfg_prdata = 32'(short_min_r);
      csm_pkg::REG_SHORT_MAX:  cfg_prdata = 32'(short_max_r);
      csm_pkg::REG_LONG_MIN:   cfg_prdata = 32'(long_min_r);
      csm_pkg::REG_BLINK_HALF: cfg_prdata = 32'(blink_half_r);
      csm_pkg::REG_DOT_HALF:   cfg_prdata = 32'(dot_half_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic              s1_valid_r, out_valid_r;
  csm_pkg::in_word_t s1_word_r;
  csm_pkg::out_word_t out_word_r, out_word_nxt;
  logic              out_open, s1_adv, in_acc;

  assign out_open = !out_valid_r || !out_stall;   // result reg can load
  assign s1_adv   = s1_valid_r && out_open;       // tick is processed now
  assign in_stall = s1_valid_r && !out_open;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)      s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv)          out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_word_r <= in_word;
    if (s1_adv) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------- tick state ----------------
  logic [1:0]  menu_r, menu_nxt;
  logic        held_r, held_nxt;
  logic [10:0] ticks_r, ticks_nxt;
  logic [9:0]  blink_cnt_r, blink_cnt_nxt;
  logic        blink_ph_r, blink_ph_nxt;
  logic [10:0] dot_cnt_r, dot_cnt_nxt;
  logic        dot_ph_r, dot_ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r      <= csm_pkg::MENU_SHOW;
      held_r      <= 1'b0;
      ticks_r     <= '0;
      blink_cnt_r <= '0;
      blink_ph_r  <= 1'b0;
      dot_cnt_r   <= '0;
      dot_ph_r    <= 1'b0;
    end else if (s1_adv) begin
      menu_r      <= menu_nxt;
      held_r      <= held_nxt;
      ticks_r     <= ticks_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_ph_r  <= blink_ph_nxt;
      dot_cnt_r   <= dot_cnt_nxt;
      dot_ph_r    <= dot_ph_nxt;
    end
  end

  // ---------------- single-pass tick logic ----------------
  logic [11:0] dot_el_w;
  logic [10:0] dot_el, ticks_inc;
  logic [10:0] blink_el_w;
  logic [9:0]  blink_el;
  logic [2:0]  m_tens, h_tens;
  logic [3:0]  m_units, h_units;
  logic [7:0]  b0, b1, b2, b3;
  logic [3:0]  en;
  logic        ev_short, ev_long, released;
  logic [4:0]  hrs;
  logic [5:0]  mins;

  assign hrs  = s1_word_r.time_hours;
  assign mins = s1_word_r.time_minutes;

  always_comb begin
    // timers: saturating elapsed count, toggle at half period
    dot_el_w = {1'b0, dot_cnt_r} + 12'd1;
    dot_el   = dot_el_w[11] ? csm_pkg::TICKS_MAX : dot_el_w[10:0];
    if (dot_el >= dot_half_r) begin
      dot_ph_nxt  = !dot_ph_r;
      dot_cnt_nxt = '0;
    end else begin
      dot_ph_nxt  = dot_ph_r;
      dot_cnt_nxt = dot_el;
    end
    blink_el_w = {1'b0, blink_cnt_r} + 11'd1;
    blink_el   = blink_el_w[10] ? csm_pkg::BLINK_MAX : blink_el_w[9:0];
    if (blink_el >= blink_half_r) begin
      blink_ph_nxt  = !blink_ph_r;
      blink_cnt_nxt = '0;
    end else begin
      blink_ph_nxt  = blink_ph_r;
      blink_cnt_nxt = blink_el;
    end

    // display digits from the raw time
    m_tens  = csm_pkg::tens6(mins);
    m_units = csm_pkg::units6(mins, m_tens);
    h_tens  = csm_pkg::tens6({1'b0, hrs});
    h_units = csm_pkg::units6({1'b0, hrs}, h_tens);
    b0 = csm_pkg::seg_code(m_units);
    b1 = csm_pkg::seg_code({1'b0, m_tens});
    b2 = csm_pkg::seg_code(h_units);
    b2 = dot_ph_nxt ? (b2 & csm_pkg::SEG_DOT_CLR) : (b2 | csm_pkg::SEG_DOT_SET);
    b3 = (h_tens != 3'd0) ? csm_pkg::seg_code({1'b0, h_tens}) : csm_pkg::SEG_BLANK;

    // blink uses the menu state at tick start
    en = 4'hF;
    if (blink_ph_nxt) begin
      case (menu_r)
        csm_pkg::MENU_SET_MIN: en = 4'hC;
        csm_pkg::MENU_SET_HR:  en = 4'h3;
        default:               en = 4'hF;
      endcase
    end

    // press timing; the release tick counts too
    ticks_inc = (ticks_r == csm_pkg::TICKS_MAX) ? ticks_r : ticks_r + 11'd1;
    released  = s1_word_r.key_level && held_r;
    held_nxt  = held_r;
    ticks_nxt = ticks_r;
    if (!s1_word_r.key_level) begin
      held_nxt  = 1'b1;
      ticks_nxt = held_r ? ticks_inc : 11'd0;
    end else if (held_r) begin
      held_nxt  = 1'b0;
      ticks_nxt = '0;
    end
    ev_long  = released && (ticks_inc >= long_min_r);
    ev_short = released && !ev_long &&
               (ticks_inc >= short_min_r) && (ticks_inc <= short_max_r);

    // menu
    menu_nxt = menu_r;
    out_word_nxt.write_time  = 1'b0;
    out_word_nxt.new_hours   = '0;
    out_word_nxt.new_minutes = '0;
    case (menu_r)
      csm_pkg::MENU_SET_MIN: begin
        if (ev_short) begin
          out_word_nxt.write_time  = 1'b1;
          out_word_nxt.new_hours   = hrs;
          out_word_nxt.new_minutes = (mins >= csm_pkg::MINUTES_TOP) ? 6'd0 : mins + 6'd1;
        end else if (ev_long) begin
          menu_nxt = csm_pkg::MENU_SET_HR;
        end
      end
      csm_pkg::MENU_SET_HR: begin
        if (ev_short) begin
          out_word_nxt.write_time  = 1'b1;
          out_word_nxt.new_minutes = mins;
          out_word_nxt.new_hours   = (hrs >= csm_pkg::HOURS_TOP) ? 5'd0 : hrs + 5'd1;
        end else if (ev_long) begin
          menu_nxt = csm_pkg::MENU_SHOW;
        end
      end
      default: begin
        if (ev_long) menu_nxt = csm_pkg::MENU_SET_MIN;
      end
    endcase

    out_word_nxt.digit_segments = {b3, b2, b1, b0};
    out_word_nxt.anode_enable   = en;
    out_word_nxt.menu_mode      = menu_nxt;
  end

endmodule

[sv/csm_chk.sv]
// Port-level checker for the clock set menu, bound to the top level.
module csm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input csm_pkg::out_word_t  out_word
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  // a time write only happens from a set state, which it does not leave
  a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.write_time |->
      (out_word.menu_mode == csm_pkg::MENU_SET_MIN) ||
      (out_word.menu_mode == csm_pkg::MENU_SET_HR))
    else $error("time write outside set state");

  // no write means zero write fields
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.write_time |->
      (out_word.new_hours == 5'd0) && (out_word.new_minutes == 6'd0))
    else $error("write fields set without a write");

  // the stepped field stays in range
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.write_time |->
      ((out_word.menu_mode == csm_pkg::MENU_SET_MIN) &&
       (out_word.new_minutes <= csm_pkg::MINUTES_TOP)) ||
      ((out_word.menu_mode == csm_pkg::MENU_SET_HR) &&
       (out_word.new_hours <= csm_pkg::HOURS_TOP)))
    else $error("stepped time field out of range");

endmodule

bind clock_set_menu_with_display csm_chk u_csm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[dv/tb_clock_set_menu_with_display.sv]
// Self-checking testbench for the clock set menu: key timing, menu, time writes and display.
`timescale 1ns / 1ps

module tb_clock_set_menu_with_display;

  // Idling profiles for the two channels
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Outcome of a completed key press
  typedef enum logic [1:0] {PRESS_NONE, PRESS_SHORT, PRESS_LONG} press_t;

  // Active-low PGFEDCBA digit codes, point off
  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                        clk;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  csm_pkg::in_word_t           in_word     = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  csm_pkg::out_word_t          out_word;
  logic                        cfg_psel    = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite  = 1'b0;
  logic [csm_pkg::CFG_AW-1:0]  cfg_paddr   = '0;
  logic [csm_pkg::CFG_DW-1:0]  cfg_pwdata  = '0;
  logic [csm_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                        cfg_pready;

  clock_set_menu_with_display DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  csm_pkg::out_word_t pending_results[$];   // predicted result words, oldest first
  int        fail_count      = 0;
  int        words_sent      = 0;
  int        results_checked = 0;
  int        writes_seen     = 0;
  int        send_idle_pct   = 0;  // chance per cycle that the sender holds off
  int        stall_pct       = 0;  // chance per cycle that the receiver stalls

  // ---------------------------------------------------------------------------
  // Predictor copy of the timing registers and block state
  // ---------------------------------------------------------------------------
  logic [10:0] short_min  = csm_pkg::RST_SHORT_MIN;
  logic [10:0] short_max  = csm_pkg::RST_SHORT_MAX;
  logic [10:0] long_min   = csm_pkg::RST_LONG_MIN;
  logic [9:0]  blink_half = csm_pkg::RST_BLINK_HALF;
  logic [10:0] dot_half   = csm_pkg::RST_DOT_HALF;

  logic [1:0]  menu_q      = csm_pkg::MENU_SHOW;
  logic        key_down    = 1'b0;
  logic [10:0] press_count = '0;
  logic [9:0]  blink_count = '0;
  logic        blink_on    = 1'b0;
  logic [10:0] dot_count   = '0;
  logic        dot_on      = 1'b0;

  // One millisecond tick: advance timers, build the display, time the key,
  // then let a finished press drive the menu. Updates predictor state.
  function automatic csm_pkg::out_word_t tick_result(input csm_pkg::in_word_t w);
    csm_pkg::out_word_t r;
    logic [1:0]  menu_at_start;
    logic [11:0] dot_elapsed;
    logic [10:0] blink_elapsed;
    logic [10:0] press_len;
    logic [7:0]  hr_units_seg;
    press_t      press;
    int          hr;
    int          mn;
    r             = '0;
    press         = PRESS_NONE;
    menu_at_start = menu_q;
    hr            = int'(w.time_hours);
    mn            = int'(w.time_minutes);

    // timers: elapsed saturates at counter width, toggle on reaching half period
    dot_elapsed = {1'b0, dot_count} + 12'd1;
    if (dot_elapsed > {1'b0, csm_pkg::TICKS_MAX}) dot_elapsed = {1'b0, csm_pkg::TICKS_MAX};
    if (dot_elapsed >= {1'b0, dot_half}) begin
      dot_on    = ~dot_on;
      dot_count = '0;
    end else begin
      dot_count = dot_elapsed[10:0];
    end
    blink_elapsed = {1'b0, blink_count} + 11'd1;
    if (blink_elapsed > {1'b0, csm_pkg::BLINK_MAX}) blink_elapsed = {1'b0, csm_pkg::BLINK_MAX};
    if (blink_elapsed >= {1'b0, blink_half}) begin
      blink_on    = ~blink_on;
      blink_count = '0;
    end else begin
      blink_count = blink_elapsed[9:0];
    end

    // display from raw time; dot rides on the hours units digit
    hr_units_seg = DIGIT_SEG[hr % 10];
    hr_units_seg = dot_on ? (hr_units_seg & csm_pkg::SEG_DOT_CLR)
                          : (hr_units_seg | csm_pkg::SEG_DOT_SET);
    r.digit_segments = {((hr / 10) != 0) ? DIGIT_SEG[hr / 10] : csm_pkg::SEG_BLANK,
                        hr_units_seg, DIGIT_SEG[mn / 10], DIGIT_SEG[mn % 10]};

    // blanking follows the menu state held at tick start
    r.anode_enable = 4'hF;
    if (blink_on) begin
      if (menu_at_start == csm_pkg::MENU_SET_MIN)     r.anode_enable = 4'hC;
      else if (menu_at_start == csm_pkg::MENU_SET_HR) r.anode_enable = 4'h3;
    end

    // press timing; the release tick counts too
    if (!w.key_level) begin
      if (!key_down) begin
        key_down    = 1'b1;
        press_count = '0;
      end else if (press_count != csm_pkg::TICKS_MAX) begin
        press_count = press_count + 11'd1;
      end
    end else if (key_down) begin
      press_len = (press_count == csm_pkg::TICKS_MAX) ? press_count : press_count + 11'd1;
      if (press_len >= short_min && press_len <= short_max) press = PRESS_SHORT;
      if (press_len >= long_min) press = PRESS_LONG;  // long wins
      key_down    = 1'b0;
      press_count = '0;
    end

    case (menu_q)
      csm_pkg::MENU_SET_MIN: begin
        if (press == PRESS_SHORT) begin
          r.write_time  = 1'b1;
          r.new_hours   = w.time_hours;
          r.new_minutes = (w.time_minutes >= csm_pkg::MINUTES_TOP) ? 6'd0
                                                                  : w.time_minutes + 6'd1;
        end else if (press == PRESS_LONG) begin
          menu_q = csm_pkg::MENU_SET_HR;
        end
      end
      csm_pkg::MENU_SET_HR: begin
        if (press == PRESS_SHORT) begin
          r.write_time  = 1'b1;
          r.new_minutes = w.time_minutes;
          r.new_hours   = (w.time_hours >= csm_pkg::HOURS_TOP) ? 5'd0 : w.time_hours + 5'd1;
        end else if (press == PRESS_LONG) begin
          menu_q = csm_pkg::MENU_SHOW;
        end
      end
      default: begin
        if (press == PRESS_LONG) menu_q = csm_pkg::MENU_SET_MIN;
      end
    endcase
    r.menu_mode = menu_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare each accepted word with the oldest
  // prediction. Sampling right after the edge sees pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    csm_pkg::out_word_t exp_w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with no prediction pending");
          fail_count++;
        end else begin
          exp_w = pending_results.pop_front();
          results_checked++;
          if (exp_w.write_time) writes_seen++;
          if (out_word.write_time !== exp_w.write_time) begin
            $error("write_time expected %0d got %0d", exp_w.write_time, out_word.write_time);
            fail_count++;
          end
          if (out_word.new_hours !== exp_w.new_hours) begin
            $error("new_hours expected %0d got %0d", exp_w.new_hours, out_word.new_hours);
            fail_count++;
          end
          if (out_word.new_minutes !== exp_w.new_minutes) begin
            $error("new_minutes expected %0d got %0d", exp_w.new_minutes,
                   out_word.new_minutes);
            fail_count++;
          end
          if (out_word.digit_segments !== exp_w.digit_segments) begin
            $error("digit_segments expected %08h got %08h", exp_w.digit_segments,
                   out_word.digit_segments);
            fail_count++;
          end
          if (out_word.anode_enable !== exp_w.anode_enable) begin
            $error("anode_enable expected %h got %h", exp_w.anode_enable,
                   out_word.anode_enable);
            fail_count++;
          end
          if (out_word.menu_mode !== exp_w.menu_mode) begin
            $error("menu_mode expected %0d got %0d", exp_w.menu_mode, out_word.menu_mode);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one tick word; valid stays up after acceptance so back-to-back words
  // need no extra assignment. Prediction happens at the accepting edge.
  task automatic send_tick(input csm_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(tick_result(w));
    words_sent++;
  endtask

  // Key down for n ticks, then one release tick; duration seen is n
  task automatic hold_key(input int n, input logic [4:0] hr, input logic [5:0] mn);
    repeat (n) send_tick(csm_pkg::in_word_t'{1'b0, hr, mn});
    send_tick(csm_pkg::in_word_t'{1'b1, hr, mn});
  endtask

  // Mostly legal clock time, now and then any value the field allows
  function automatic csm_pkg::in_word_t random_tick(input logic key);
    csm_pkg::in_word_t w;
    w.key_level = key;
    if ($urandom_range(7) == 0) begin
      w.time_hours   = 5'($urandom);
      w.time_minutes = 6'($urandom);
    end else begin
      w.time_hours   = 5'($urandom_range(23));
      w.time_minutes = 6'($urandom_range(59));
    end
    return w;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 74; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 74; end
      IDLE_BOTH:     begin send_idle_pct = 8;  stall_pct = 8;  end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Stop offering words and wait for every predicted word to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then idle with psel low
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= csm_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      csm_pkg::REG_SHORT_MIN:  short_min  = value[10:0];
      csm_pkg::REG_SHORT_MAX:  short_max  = value[10:0];
      csm_pkg::REG_LONG_MIN:   long_min   = value[10:0];
      csm_pkg::REG_BLINK_HALF: blink_half = value[9:0];
      csm_pkg::REG_DOT_HALF:   dot_half   = value[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reprogram all five timing registers once the block has gone idle
  task automatic program_timing(input logic [10:0] smin, input logic [10:0] smax,
                                input logic [10:0] lmin, input logic [9:0] blink,
                                input logic [10:0] dot);
    drain_results();
    cfg_write(csm_pkg::REG_SHORT_MIN,  32'(smin));
    cfg_write(csm_pkg::REG_SHORT_MAX,  32'(smax));
    cfg_write(csm_pkg::REG_LONG_MIN,   32'(lmin));
    cfg_write(csm_pkg::REG_BLINK_HALF, 32'(blink));
    cfg_write(csm_pkg::REG_DOT_HALF,   32'(dot));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Display extremes at reset bounds, then a full walk through the menu with
  // wrap of minutes and hours, including values above the legal range.
  task automatic test_directed_menu();
    set_idle(IDLE_NONE);
    // reset bounds: a one-tick press is too short for any event
    send_tick(csm_pkg::in_word_t'{1'b1, 5'd0, 6'd0});
    send_tick(csm_pkg::in_word_t'{1'b0, 5'd23, 6'd59});
    send_tick(csm_pkg::in_word_t'{1'b1, 5'd31, 6'd63});
    // short is exactly 2 ticks, long 3 or more; blink and dot toggle each tick
    program_timing(11'd2, 11'd2, 11'd3, 10'd1, 11'd0);
    hold_key(2, 5'd19, 6'd30);  // short in show: ignored
    hold_key(3, 5'd12, 6'd34);  // long: to set minutes
    hold_key(2, 5'd31, 6'd59);  // minutes wrap, odd hours passed through
    hold_key(2, 5'd10, 6'd63);  // wrap from above the top
    hold_key(3, 5'd8,  6'd8);   // long: to set hours
    hold_key(2, 5'd23, 6'd7);   // hours wrap
    hold_key(2, 5'd24, 6'd60);  // wrap from above the top
    hold_key(3, 5'd9,  6'd9);   // long: back to show
  endtask

  // Random press sequences shaped by the current bounds, plus noise
  task automatic test_random_menu(input idle_mode_t mode, input int n_words,
                                  input logic [10:0] smin, input logic [10:0] smax,
                                  input logic [10:0] lmin, input logic [9:0] blink,
                                  input logic [10:0] dot);
    int sent;
    int len;
    int lo;
    program_timing(smin, smax, lmin, blink, dot);
    set_idle(mode);
    sent = 0;
    while (sent < n_words) begin
      lo = (smin == 11'd0) ? 1 : int'(smin);
      case ($urandom_range(9))
        0, 1, 2, 3: len = (int'(smax) >= lo) ? int'($urandom_range(lo, int'(smax)))
                                             : int'($urandom_range(1, 8));
        4, 5:       len = ((lmin == 11'd0) ? 1 : int'(lmin)) + int'($urandom_range(2));
        6, 7:       len = int'($urandom_range(1, int'(lmin) + 4));
        default:    len = 0;
      endcase
      if (len == 0) begin
        // broken sequence: random key levels
        repeat ($urandom_range(1, 3)) begin
          send_tick(random_tick(1'($urandom_range(1))));
          sent++;
        end
      end else begin
        repeat (len) begin
          send_tick(random_tick(1'b0));
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_tick(random_tick(1'b1));
          sent++;
        end
      end
    end
  endtask

  // Lower short bound zero, other bounds and periods at top values; short presses only
  task automatic test_bounds_at_max();
    program_timing(11'd0, 11'd2047, 11'd2047, 10'd1023, 11'd2047);
    set_idle(IDLE_NONE);
    hold_key(1, 5'd20, 6'd0);      // shortest press: short with zero lower bound
    hold_key(6, 5'd16, 6'd38);     // short well below the long bound
    hold_key(0, 5'd7, 6'd45);      // release without a press: no event
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_menu();
    test_random_menu(IDLE_NONE,     300, 11'd2, 11'd6,  11'd9,  10'd3,    11'd5);
    // long bound inside the short window: long wins
    test_random_menu(IDLE_SENDER,   300, 11'd1, 11'd4,  11'd4,  10'd1,    11'd0);
    test_random_menu(IDLE_RECEIVER, 300, 11'd3, 11'd12, 11'd14, 10'd7,    11'd11);
    // all bounds zero: every release is long
    test_random_menu(IDLE_BOTH,     250, 11'd0, 11'd0,  11'd0,  10'd1023, 11'd2047);
    test_random_menu(IDLE_BOTH,     250, 11'($urandom_range(5)), 11'($urandom_range(3, 12)),
                     11'($urandom_range(20)), 10'($urandom_range(1, 40)),
                     11'($urandom_range(60)));
    test_random_menu(IDLE_NONE,     250, 11'($urandom_range(5)), 11'($urandom_range(3, 12)),
                     11'($urandom_range(20)), 10'($urandom_range(1, 40)),
                     11'($urandom_range(60)));
    test_bounds_at_max();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d result words for %0d ticks sent; %0d carried a time write.",
             results_checked, words_sent, writes_seen);
    $display("Covered: directed menu walk, random press phases under idling, top bounds.");
    if (fail_count == 0) begin
      $display("clock_set_menu_with_display test passed");
    end else begin
      $display("clock_set_menu_with_display test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("clock_set_menu_with_display test failed");
    $finish;
  end

endmodule
